>>> design/accel_tilt_angles_assert.svh
// Assertion macros for the tilt angle pipeline.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ATA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ATA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/atilt_pkg.sv
// Shared constants for the tilt angle pipeline.
`default_nettype none

package atilt_pkg;

   localparam int SQRT_STEPS   = 32;   // one root bit per stage
   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 60;   // CORDIC vector width
   localparam int AW           = 34;   // Q4.30 angle accumulator width
   localparam int SQ_RW        = 36;   // square root remainder width
   localparam int MW           = AW + 13;

   localparam logic signed [AW-1:0] HALF_PI_Q30    = 34'sh6487ED51;
   localparam logic [12:0]          DEG100_PER_RAD = 13'd5730;
   localparam logic [18:0]          LEVER_MUL      = 19'd341;    // 1023/600 = 341/200
   localparam logic [15:0]          RECIP_25       = 16'd41944;  // ceil(2^20 / 25)
   localparam logic signed [16:0]   LEVER_OFFSET   = 17'sd300;
   localparam logic signed [16:0]   LEVER_SPAN     = 17'sd600;
   localparam logic [9:0]           LEVER_MAX      = 10'd1023;

   localparam logic [29:0] ATAN_TABLE [CORDIC_STEPS] = '{
      30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
      30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
      30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
      30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
      30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
      30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
   };

endpackage

`default_nettype wire

>>> design/atilt_intf.sv
// Request and response channel interfaces of the tilt angle block.
`default_nettype none

interface atilt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] x_low_byte;
   logic [7:0] x_high_byte;
   logic [7:0] y_low_byte;
   logic [7:0] y_high_byte;
   logic [7:0] z_low_byte;
   logic [7:0] z_high_byte;

   modport source (output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                   z_low_byte, z_high_byte, input ready);
   modport sink   (input valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                   z_low_byte, z_high_byte, output ready);
endinterface

interface atilt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_centideg;
   logic signed [14:0] pitch_centideg;
   logic [9:0]         x_lever;
   logic [9:0]         y_lever;

   modport source (output valid, roll_centideg, pitch_centideg, x_lever, y_lever,
                   input ready);
   modport sink   (input valid, roll_centideg, pitch_centideg, x_lever, y_lever,
                   output ready);
endinterface

`default_nettype wire

>>> design/accel_tilt_angles.sv
// Tilt angle block: roll, pitch and lever values from one accelerometer sample.
//
// Takes one request per cycle and returns one response per request, in order.
// The 32-stage digit-by-digit square root of y*y+z*z and the 31-stage CORDIC
// (quadrant turn plus 30 steps) that runs roll and pitch side by side make up
// most of the pipeline; a multiply stage and a rounding stage finish the
// angles. The whole pipeline advances together: while a response waits at the
// output, every stage holds and no request is taken.
`default_nettype none

module accel_tilt_angles (
   input wire logic   clock,
   input wire logic   reset,
   atilt_req_if.sink  req_ch,
   atilt_rsp_if.source rsp_ch
);
   import atilt_pkg::*;

   localparam int ST_SQ0 = 3;
   localparam int ST_C0  = ST_SQ0 + SQRT_STEPS;
   localparam int ST_MUL = ST_C0 + CORDIC_STEPS + 1;
   localparam int ST_OUT = ST_MUL + 1;
   localparam int NV     = ST_OUT + 1;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [9:0]         xl;
      logic [9:0]         yl;
      logic               roll_zero;
      logic               pitch_zero;
   } side_type;

   typedef struct packed {
      logic [18:0] w;
      logic        lo;
      logic        hi;
   } lev_type;

   typedef struct packed {
      logic [SQ_RW-1:0] rem;
      logic [31:0]      root;
      logic [31:0]      n;
      side_type         side;
   } sq_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] a;
   } vec_type;

   typedef struct packed {
      vec_type  r;
      vec_type  p;
      side_type side;
   } cst_type;

   function automatic vec_type quad_turn(vec_type v);
      vec_type o;
      o = v;
      if (v.x < 0) begin
         if (v.y >= 0) begin
            o.x = v.y;
            o.y = -v.x;
            o.a = HALF_PI_Q30;
         end else begin
            o.x = -v.y;
            o.y = v.x;
            o.a = -HALF_PI_Q30;
         end
      end
      return o;
   endfunction

   function automatic vec_type cordic_iter(vec_type v, int i);
      vec_type              o;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [AW-1:0] t;
      dx = v.x;
      dy = v.y;
      dx = v.y >>> i;
      dy = v.x >>> i;
      t  = signed'({4'b0000, ATAN_TABLE[i]});
      if (v.y > 0) begin
         o.x = v.x + dx;
         o.y = v.y - dy;
         o.a = v.a + t;
      end else begin
         o.x = v.x - dx;
         o.y = v.y + dy;
         o.a = v.a - t;
      end
      return o;
   endfunction

   function automatic logic [9:0] div200(logic [18:0] w);
      logic [15:0] u;
      logic [31:0] p;
      u = w[18:3];
      p = u * RECIP_25;
      return p[29:20];
   endfunction

   // ---------------------------------------------------------------- control
   logic          advance;
   logic [NV-1:0] vld_ff;
   logic [NV-1:0] vld_in;

   assign advance      = !vld_ff[ST_OUT] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign vld_in       = {vld_ff[NV-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------ assemble, squares
   logic signed [15:0] x0_ff, y0_ff, z0_ff;
   logic signed [15:0] x0_in, y0_in, z0_in;
   logic [30:0]        ysq1_ff, zsq1_ff, ysq1_in, zsq1_in;
   logic signed [15:0] x1_ff, y1_ff, z1_ff;
   logic               rz1_ff, pz1_ff, rz1_in, pz1_in;
   lev_type            lx1_ff, ly1_ff, lx1_in, ly1_in;
   logic [31:0]        sum2_ff, sum2_in;
   side_type           side2_ff, side2_in;
   logic signed [16:0] tx, ty;
   logic [9:0]         qx, qy;

   assign x0_in = signed'({req_ch.x_high_byte, req_ch.x_low_byte});
   assign y0_in = signed'({req_ch.y_high_byte, req_ch.y_low_byte});
   assign z0_in = signed'({req_ch.z_high_byte, req_ch.z_low_byte});

   always_comb begin
      ysq1_in = 31'(y0_ff * y0_ff);
      zsq1_in = 31'(z0_ff * z0_ff);
      rz1_in  = (y0_ff == 16'sd0) && (z0_ff == 16'sd0);
      pz1_in  = rz1_in && (x0_ff == 16'sd0);
      tx      = 17'(x0_ff) + LEVER_OFFSET;
      ty      = 17'(y0_ff) + LEVER_OFFSET;
      lx1_in.w  = 19'(tx[9:0]) * LEVER_MUL;
      lx1_in.lo = tx < 0;
      lx1_in.hi = tx > LEVER_SPAN;
      ly1_in.w  = 19'(ty[9:0]) * LEVER_MUL;
      ly1_in.lo = ty < 0;
      ly1_in.hi = ty > LEVER_SPAN;
   end

   always_comb begin
      qx = div200(lx1_ff.w);
      qy = div200(ly1_ff.w);
      sum2_in = 32'(ysq1_ff) + 32'(zsq1_ff);
      side2_in.x = x1_ff;
      side2_in.y = y1_ff;
      side2_in.z = z1_ff;
      side2_in.roll_zero  = rz1_ff;
      side2_in.pitch_zero = pz1_ff;
      // x lever runs downward: below range saturates high
      if (lx1_ff.lo)      side2_in.xl = LEVER_MAX;
      else if (lx1_ff.hi) side2_in.xl = '0;
      else                side2_in.xl = LEVER_MAX - qx;
      if (ly1_ff.lo)      side2_in.yl = '0;
      else if (ly1_ff.hi) side2_in.yl = LEVER_MAX;
      else                side2_in.yl = qy;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         z0_ff    <= z0_in;
         ysq1_ff  <= ysq1_in;
         zsq1_ff  <= zsq1_in;
         x1_ff    <= x0_ff;
         y1_ff    <= y0_ff;
         z1_ff    <= z0_ff;
         rz1_ff   <= rz1_in;
         pz1_ff   <= pz1_in;
         lx1_ff   <= lx1_in;
         ly1_ff   <= ly1_in;
         sum2_ff  <= sum2_in;
         side2_ff <= side2_in;
      end
   end

   // ------------------------------------------ square root, one bit a stage
   // Radicand is sum * 2^32; its low half is zero, so zeros shift in.
   sq_type sq_ff [SQRT_STEPS];
   sq_type sq_in [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      sq_type           src;
      logic [SQ_RW-1:0] rem_t;
      logic [SQ_RW-1:0] trial;

      if (k == 0) begin : g_first
         assign src = '{rem: '0, root: '0, n: sum2_ff, side: side2_ff};
      end else begin : g_next
         assign src = sq_ff[k-1];
      end

      always_comb begin
         rem_t = {src.rem[SQ_RW-3:0], src.n[31:30]};
         trial = SQ_RW'({src.root, 2'b01});
         sq_in[k].side = src.side;
         sq_in[k].n    = {src.n[29:0], 2'b00};
         if (rem_t >= trial) begin
            sq_in[k].rem  = rem_t - trial;
            sq_in[k].root = {src.root[30:0], 1'b1};
         end else begin
            sq_in[k].rem  = rem_t;
            sq_in[k].root = {src.root[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // --------------------------------------------------------------- CORDIC
   cst_type cs_ff [CORDIC_STEPS+1];
   cst_type cs_in [CORDIC_STEPS+1];

   always_comb begin
      vec_type rv;
      vec_type pv;
      rv.x = CW'(sq_ff[SQRT_STEPS-1].side.z) <<< 40;
      rv.y = CW'(sq_ff[SQRT_STEPS-1].side.y) <<< 40;
      rv.a = '0;
      pv.x = signed'(CW'({sq_ff[SQRT_STEPS-1].root, 24'b0}));
      pv.y = (-CW'(sq_ff[SQRT_STEPS-1].side.x)) <<< 40;
      pv.a = '0;
      cs_in[0].r    = quad_turn(rv);
      cs_in[0].p    = quad_turn(pv);
      cs_in[0].side = sq_ff[SQRT_STEPS-1].side;
   end

   for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_cordic
      always_comb begin
         cs_in[j].r    = cordic_iter(cs_ff[j-1].r, j - 1);
         cs_in[j].p    = cordic_iter(cs_ff[j-1].p, j - 1);
         cs_in[j].side = cs_ff[j-1].side;
      end
   end

   for (genvar j = 0; j <= CORDIC_STEPS; j++) begin : g_cordic_reg
      always_ff @(posedge clock) begin
         if (advance) begin
            cs_ff[j] <= cs_in[j];
         end
      end
   end

   // -------------------------------------------- scale to centidegrees, round
   logic [MW-1:0]        rmul_ff, pmul_ff, rmul_in, pmul_in;
   logic                 rneg_ff, pneg_ff;
   logic [9:0]           xl_m_ff, yl_m_ff;
   logic signed [AW-1:0] ra, pa;
   logic [AW-1:0]        ramag, pamag;

   always_comb begin
      ra    = cs_ff[CORDIC_STEPS].r.a;
      pa    = cs_ff[CORDIC_STEPS].p.a;
      ramag = ra[AW-1] ? AW'(-ra) : AW'(ra);
      pamag = pa[AW-1] ? AW'(-pa) : AW'(pa);
      rmul_in = cs_ff[CORDIC_STEPS].side.roll_zero  ? '0 : MW'(ramag) * MW'(DEG100_PER_RAD);
      pmul_in = cs_ff[CORDIC_STEPS].side.pitch_zero ? '0 : MW'(pamag) * MW'(DEG100_PER_RAD);
   end

   logic [MW-1:0]      rrnd, prnd;
   logic [15:0]        rq, pq;
   logic signed [15:0] roll_ff, roll_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic [9:0]         xl_ff, yl_ff;

   always_comb begin
      // ties round away from zero: round the magnitude, then apply the sign
      rrnd     = rmul_ff + MW'(1 << 29);
      prnd     = pmul_ff + MW'(1 << 29);
      rq       = rrnd[45:30];
      pq       = prnd[45:30];
      roll_in  = rneg_ff ? -signed'(rq) : signed'(rq);
      pitch_in = pneg_ff ? 15'(-signed'(pq)) : 15'(signed'(pq));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rmul_ff  <= rmul_in;
         pmul_ff  <= pmul_in;
         rneg_ff  <= ra[AW-1];
         pneg_ff  <= pa[AW-1];
         xl_m_ff  <= cs_ff[CORDIC_STEPS].side.xl;
         yl_m_ff  <= cs_ff[CORDIC_STEPS].side.yl;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         xl_ff    <= xl_m_ff;
         yl_ff    <= yl_m_ff;
      end
   end

   assign rsp_ch.valid          = vld_ff[ST_OUT];
   assign rsp_ch.roll_centideg  = roll_ff;
   assign rsp_ch.pitch_centideg = pitch_ff;
   assign rsp_ch.x_lever        = xl_ff;
   assign rsp_ch.y_lever        = yl_ff;

   // ------------------------------------------------------------ assertions
`include "accel_tilt_angles_assert.svh"

   `ATA_ASSERT_NOW(a_stall_blocks_intake, rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "request taken while response stalled")
   `ATA_ASSERT_NEXT(a_request_enters, req_ch.valid && req_ch.ready, vld_ff[0], "accepted request lost at first stage")
   `ATA_ASSERT_NOW(a_pitch_range, rsp_ch.valid, (rsp_ch.pitch_centideg >= -15'sd9001) && (rsp_ch.pitch_centideg <= 15'sd9001), "pitch out of range")
   `ATA_ASSERT_NOW(a_roll_range, rsp_ch.valid, (rsp_ch.roll_centideg >= -16'sd18002) && (rsp_ch.roll_centideg <= 16'sd18002), "roll out of range")

endmodule

`default_nettype wire

>>> sim/atilt_tb_intf.sv
// Testbench types: the expected response record of the tilt angle block.
`timescale 1ns / 100ps
package atilt_tb_types;
   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic [9:0]         x_lever;
      logic [9:0]         y_lever;
   } tilt_result_type;
endpackage

>>> sim/testbench.sv
// Testbench for the tilt angle block: predicted angles and levers checked per response.
`timescale 1ns / 100ps

module testbench;
   import atilt_pkg::*;
   import atilt_tb_types::*;

   logic clock = 0;
   logic reset = 1;
   atilt_req_if req_ch();
   atilt_rsp_if rsp_ch();

   accel_tilt_angles DUT (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   always #1 clock = ~clock;

   tilt_result_type expected_tilts[$];
   int  fail_count = 0;
   bit  src_idle_on = 1, snk_idle_on = 1;
   int  hold_cycles = 0;

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint isqrt(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint vector_angle(longint cx, longint cy);
      longint a = 0, t, dx, dy;
      if (cx == 0 && cy == 0) return 0;
      if (cx < 0) begin
         t = cx;
         if (cy >= 0) begin
            cx = cy; cy = -t; a = HALF_PI_Q30;
         end else begin
            cx = -cy; cy = t; a = -HALF_PI_Q30;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = shift_floor(cy, i);
         dy = shift_floor(cx, i);
         if (cy > 0) begin
            cx += dx; cy -= dy; a += longint'(ATAN_TABLE[i]);
         end else begin
            cx -= dx; cy += dy; a -= longint'(ATAN_TABLE[i]);
         end
      end
      return a;
   endfunction

   function automatic longint centideg(longint a);
      longint unsigned m = (a < 0 ? -a : a) * 5730;
      longint q = (m + (64'd1 << 29)) >> 30;
      return a < 0 ? -q : q;
   endfunction

   function automatic logic [9:0] clamp_lever(longint v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v[9:0];
   endfunction

   function automatic tilt_result_type predict_tilt(logic [15:0] xw, logic [15:0] yw,
                                                    logic [15:0] zw);
      longint x = longint'($signed(xw));
      longint y = longint'($signed(yw));
      longint z = longint'($signed(zw));
      longint m = isqrt(longint'(y*y + z*z) << 32);
      tilt_result_type r;
      r.roll    = 16'(centideg(vector_angle(z <<< 40, y <<< 40)));
      r.pitch   = 15'(centideg(vector_angle(m <<< 24, (-x) <<< 40)));
      r.x_lever = clamp_lever((x + 300) * (-1023) / 600 + 1023);
      r.y_lever = clamp_lever((y + 300) * 1023 / 600);
      return r;
   endfunction

   // valid drops only for an idle burst, so back-to-back requests keep it high
   task automatic src_gap();
      int n;
      if (src_idle_on && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 9);
         req_ch.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_sample(logic [15:0] xw, logic [15:0] yw, logic [15:0] zw);
      src_gap();
      req_ch.valid       <= 1;
      req_ch.x_low_byte  <= xw[7:0];
      req_ch.x_high_byte <= xw[15:8];
      req_ch.y_low_byte  <= yw[7:0];
      req_ch.y_high_byte <= yw[15:8];
      req_ch.z_low_byte  <= zw[7:0];
      req_ch.z_high_byte <= zw[15:8];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_tilts.push_back(predict_tilt(xw, yw, zw));
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (expected_tilts.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, or a long hold when requested
   initial begin
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 0;
            hold_cycles--;
         end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 9) - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      tilt_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_tilts.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            e = expected_tilts.pop_front();
            if (rsp_ch.roll_centideg !== e.roll) begin
               $error("roll_centideg exp %0d got %0d", e.roll, rsp_ch.roll_centideg);
               fail_count++;
            end
            if (rsp_ch.pitch_centideg !== e.pitch) begin
               $error("pitch_centideg exp %0d got %0d", e.pitch, rsp_ch.pitch_centideg);
               fail_count++;
            end
            if (rsp_ch.x_lever !== e.x_lever) begin
               $error("x_lever exp %0d got %0d", e.x_lever, rsp_ch.x_lever);
               fail_count++;
            end
            if (rsp_ch.y_lever !== e.y_lever) begin
               $error("y_lever exp %0d got %0d", e.y_lever, rsp_ch.y_lever);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 3))
         0: return 16'($signed($urandom_range(0, 800)) - 400);
         1: return 16'($signed($urandom_range(0, 600)) - 300);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_special_cases();
      logic [15:0] ext[5] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};
      send_sample(0, 0, 0);
      send_sample(0, 0, 16'hFF00);
      send_sample(16'h0100, 0, 0);
      send_sample(16'hFF00, 0, 0);
      send_sample(16'(300), 16'(-300), 0);
      send_sample(16'(-300), 16'(300), 0);
      send_sample(16'(301), 16'(-301), 16'(5));
      send_sample(16'(-301), 16'(301), 16'(-5));
      for (int i = 0; i < 5; i++) send_sample(ext[i], ext[(i+1)%5], ext[(i+2)%5]);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h5555, 16'hAAAA, 16'h5555);
      send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
      drain();
   endtask

   task automatic test_random_samples(int n);
      for (int i = 0; i < n; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
   endtask

   task automatic test_backpressure();
      fork
         hold_cycles = 300;
      join_none
      test_random_samples(150);
      drain();
   endtask

   initial begin
      req_ch.valid       = 0;
      req_ch.x_low_byte  = 0;
      req_ch.x_high_byte = 0;
      req_ch.y_low_byte  = 0;
      req_ch.y_high_byte = 0;
      req_ch.z_low_byte  = 0;
      req_ch.z_high_byte = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_special_cases();
      test_random_samples(500);
      test_backpressure();
      src_idle_on = 0;
      snk_idle_on = 0;
      test_random_samples(480);
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_tilts.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
